>>> src/bsc_pkg.sv
// Shared types, constants and the gray conversion for the bright spot centroid block.
package bsc_pkg;

  // Default size limits of the frame
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Field and accumulator widths
  localparam int CFG_W   = 13;
  localparam int THR_W   = 8;
  localparam int OUT_W   = 12;
  localparam int COUNT_W = 25;
  localparam int SUM_W   = 36;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 1'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST      = 13'd640;
  localparam logic [THR_W-1:0] BRIGHT_THRESHOLD_RST = 8'd252;

  // Divider: one quotient bit per cycle over the full sum width
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Gray weights, Q14
  localparam int GRAY_W = 22;
  localparam logic [GRAY_W-1:0] GRAY_WB  = 22'd1868;
  localparam logic [GRAY_W-1:0] GRAY_WG  = 22'd9617;
  localparam logic [GRAY_W-1:0] GRAY_WR  = 22'd4899;
  localparam logic [GRAY_W-1:0] GRAY_RND = 22'd8192;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       end_of_frame;
  } pix_t;

  typedef struct packed {
    logic [OUT_W-1:0]   centroid_x;
    logic [OUT_W-1:0]   centroid_y;
    logic [OUT_W-1:0]   center_x;
    logic [OUT_W-1:0]   center_y;
    logic [COUNT_W-1:0] bright_count;
    logic               no_bright;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic emit;
  } bsc_cmd_t;

  // Rounded weighted sum of the three channels
  function automatic logic [7:0] gray_level(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r);
    logic [GRAY_W-1:0] acc;
    acc = GRAY_W'(b) * GRAY_WB + GRAY_W'(g) * GRAY_WG + GRAY_W'(r) * GRAY_WR + GRAY_RND;
    return acc[GRAY_W-1:14];
  endfunction

endpackage

>>> src/bsc_ctrl.sv
// Controller: sequences pixel intake, the end-of-frame divide and the result register.
module bsc_ctrl
  import bsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pix_valid,
  input  logic      pix_eof,
  output logic      pix_stall,
  output logic      res_valid,
  input  logic      res_stall,
  output bsc_cmd_t  cmd
);

  localparam logic [1:0] ST_ACCUM = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(DIV_STEPS - 1);

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              res_valid_next;

  // Pixels are taken only while accumulating
  assign pix_stall  = (state != ST_ACCUM);
  assign cmd.accept = pix_valid && (state == ST_ACCUM);
  assign cmd.load   = (state == ST_LOAD);
  assign cmd.step   = (state == ST_DIV);
  assign cmd.emit   = (state == ST_DONE) && (!res_valid || !res_stall);

  // Next state
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      ST_ACCUM: begin
        if (cmd.accept && pix_eof) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        step_cnt_next = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (step_cnt == LastStep) begin
          state_next = ST_DONE;
        end else begin
          step_cnt_next = step_cnt + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (cmd.emit) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd.emit) begin
      res_valid_next = 1'b1;
    end else if (res_stall) begin
      res_valid_next = res_valid;
    end else begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      res_valid <= res_valid_next;
    end
  end

  // The last pixel of a frame always starts a divide
  a_eof_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && pix_eof |=> state == ST_LOAD)
    else $error("end of frame did not start the divide");

  // The step counter stays inside the divide length
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step_cnt <= LastStep)
    else $error("divide step counter out of range");

  // A finished divide hands off as soon as the result register frees up
  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !res_stall |=> state == ST_ACCUM && res_valid)
    else $error("result not loaded when output was free");

endmodule

>>> src/bsc_datapath.sv
// Datapath: gray threshold, position tracking, saturating sums, serial divider, result register.
module bsc_datapath
  import bsc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pix_t                 pix,
  input  bsc_cmd_t             cmd,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output res_t                 res
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam logic [CFG_W:0] MaxW = (CFG_W + 1)'(MAX_WIDTH);
  localparam logic [RW:0]    MaxH = (RW + 1)'(MAX_HEIGHT);

  // Configuration registers
  logic [CFG_W-1:0] frame_width;
  logic [THR_W-1:0] bright_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RST;
      bright_threshold <= BRIGHT_THRESHOLD_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:      frame_width      <= cfg_data;
        REG_BRIGHT_THRESHOLD: bright_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Width clamped to 1..MAX_WIDTH
  logic [EW-1:0] eff_w;
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if ({1'b0, frame_width} > MaxW) begin
      eff_w = EW'(MaxW);
    end else begin
      eff_w = EW'(frame_width);
    end
  end

  // Raster position of the next pixel
  logic [CW-1:0] column_pos;
  logic [RW-1:0] row_pos;
  logic          col_wrap;
  logic          row_room;

  assign col_wrap = (15'(column_pos) + 15'd1) >= 15'(eff_w);
  assign row_room = ((RW + 1)'(row_pos) + (RW + 1)'(1)) < MaxH;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (cmd.accept) begin
      if (pix.end_of_frame) begin
        column_pos <= '0;
        row_pos    <= '0;
      end else if (col_wrap) begin
        column_pos <= '0;
        if (row_room) row_pos <= row_pos + RW'(1);
      end else begin
        column_pos <= column_pos + CW'(1);
      end
    end
  end

  // Stage 1: threshold decision with the pixel's position
  logic          s1_valid;
  logic          s1_bright;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s1_bright <= gray_level(pix.blue, pix.green, pix.red) > bright_threshold;
      s1_col    <= column_pos;
      s1_row    <= row_pos;
    end
  end

  // Stage 2: saturating accumulators
  logic [COUNT_W-1:0] pixel_total, pixel_total_next;
  logic [SUM_W-1:0]   x_sum, x_sum_next;
  logic [SUM_W-1:0]   y_sum, y_sum_next;
  logic [COUNT_W:0]   cnt_add;
  logic [SUM_W:0]     x_add, y_add;

  always_comb begin
    cnt_add = (COUNT_W + 1)'(pixel_total) + (COUNT_W + 1)'(1);
    x_add   = (SUM_W + 1)'(x_sum) + (SUM_W + 1)'(s1_col);
    y_add   = (SUM_W + 1)'(y_sum) + (SUM_W + 1)'(s1_row);
    pixel_total_next = pixel_total;
    x_sum_next       = x_sum;
    y_sum_next       = y_sum;
    if (s1_valid && s1_bright) begin
      pixel_total_next = cnt_add[COUNT_W] ? '1 : cnt_add[COUNT_W-1:0];
      x_sum_next       = x_add[SUM_W] ? '1 : x_add[SUM_W-1:0];
      y_sum_next       = y_add[SUM_W] ? '1 : y_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      pixel_total <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
    end else begin
      pixel_total <= pixel_total_next;
      x_sum       <= x_sum_next;
      y_sum       <= y_sum_next;
    end
  end

  // Restoring dividers, x and y side by side, one quotient bit per step
  logic [SUM_W-1:0]   xq, yq;
  logic [COUNT_W-1:0] xr, yr;
  logic [COUNT_W-1:0] divisor;
  logic               empty;
  logic [OUT_W-1:0]   ctr_x, ctr_y;
  logic [COUNT_W:0]   x_sh, y_sh;
  logic               x_ge, y_ge;
  logic [COUNT_W:0]   x_diff, y_diff;
  logic [RW:0]        rows;

  assign rows   = (RW + 1)'(s1_row) + (RW + 1)'(1);
  assign x_sh   = {xr, xq[SUM_W-1]};
  assign y_sh   = {yr, yq[SUM_W-1]};
  assign x_ge   = x_sh >= {1'b0, divisor};
  assign y_ge   = y_sh >= {1'b0, divisor};
  assign x_diff = x_sh - {1'b0, divisor};
  assign y_diff = y_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xq      <= x_sum_next;
      yq      <= y_sum_next;
      xr      <= '0;
      yr      <= '0;
      divisor <= pixel_total_next;
      empty   <= (pixel_total_next == '0);
      ctr_x   <= OUT_W'(eff_w >> 1);
      ctr_y   <= OUT_W'(rows >> 1);
    end else if (cmd.step) begin
      xq <= {xq[SUM_W-2:0], x_ge};
      yq <= {yq[SUM_W-2:0], y_ge};
      xr <= x_ge ? x_diff[COUNT_W-1:0] : x_sh[COUNT_W-1:0];
      yr <= y_ge ? y_diff[COUNT_W-1:0] : y_sh[COUNT_W-1:0];
    end
  end

  // Result register; quotients clamp to the 12-bit range
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (empty) begin
        res.centroid_x <= '0;
        res.centroid_y <= '0;
      end else begin
        res.centroid_x <= (xq[SUM_W-1:OUT_W] != '0) ? '1 : xq[OUT_W-1:0];
        res.centroid_y <= (yq[SUM_W-1:OUT_W] != '0) ? '1 : yq[OUT_W-1:0];
      end
      res.center_x     <= ctr_x;
      res.center_y     <= ctr_y;
      res.bright_count <= divisor;
      res.no_bright    <= empty;
    end
  end

endmodule

>>> src/bright_spot_centroid_core.sv
// Top level of the bright spot centroid block: controller plus datapath.
//
// Pixels come in on the pix channel in raster order, one item per cycle
// while the block is accumulating; the item flagged end_of_frame closes
// the frame. Each pixel is reduced to gray and counted when its level is
// above the threshold register; bright pixels add their column and row to
// saturating sums. After the closing pixel the block stalls pix, divides
// both sums by the count with a serial divider that settles one quotient
// bit per cycle, and loads one result item into the res output register.
// From the closing pixel the block passes a load state, in which the last
// sum update lands, the divide steps and a done state that loads the res
// register; pix is stalled through all of them, and longer while a full
// res register is stalled. Pixels inside a frame sustain one item per cycle.
// The result waits in its register while res_stall is high; the next frame
// can stream in meanwhile, and a later result waits in the done state for that register.
// Reset returns frame_width to 640, bright_threshold to 252 and clears the
// position and sums; the cfg port writes a register by index.
module bright_spot_centroid_core
  import bsc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pix_t                 pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bsc_cmd_t cmd;

  bsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_eof   (pix.end_of_frame),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  bsc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .cmd          (cmd),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res          (res)
  );

endmodule
